// ===== hw/rtl/tkl_pkg.sv =====
package tkl_pkg;

    localparam int CNT_W   = 4;
    localparam int VALUE_W = 32;
    localparam int LABEL_W = 17;
    localparam int CAND_W  = 16;
    localparam int RANK_W  = 3;

    localparam logic [LABEL_W-1:0] LABEL_EMPTY = '1;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_OFFER = 2'd1,
        CMD_DUMP  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic             clear;
        logic             load_cand;
        logic             scan;
        logic             write;
        logic             sort;
        logic             phase;
        logic             emit;
        logic             last;
        logic [CNT_W-1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

endpackage

// ===== hw/rtl/tkl_in_if.sv =====
interface tkl_in_if
    import tkl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [1:0]          cmd;
    logic [CAND_W-1:0]   cand_label;
    logic [VALUE_W-1:0]  cand_value;

    modport source (output valid, output cmd, output cand_label, output cand_value,
                    input ready);
    modport sink   (input valid, input cmd, input cand_label, input cand_value,
                    output ready);
endinterface

// ===== hw/rtl/tkl_out_if.sv =====
interface tkl_out_if
    import tkl_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [RANK_W-1:0]          rank;
    logic signed [LABEL_W-1:0]  out_label;
    logic [VALUE_W-1:0]         out_value;
    logic                       last;

    modport source (output valid, output rank, output out_label, output out_value,
                    output last, input ready);
    modport sink   (input valid, input rank, input out_label, input out_value,
                    input last, output ready);
endinterface

// ===== hw/rtl/top_k_largest_tracker_top.sv =====
// Keeps the largest values offered during one frame, each with its label.
// Transactions arrive on cmd_ch: a clear empties every slot, an offer replaces the
// first slot holding the smallest value when the offered value is strictly larger,
// and a dump returns the slots in use on res_ch in descending order, ties in slot
// order, with last set on the final transaction; the slots are then kept sorted.
// The slot count is written through cfg_we and cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this. Zero
// turns every command into a no-op, and counts above MAX_SLOTS saturate. Only one
// command is in progress at a time. A clear is done in the idle state; an offer
// runs a serial scan for the minimum over one shared read port, then writes. A
// dump runs odd-even sorting passes and then delivers one result per cycle while
// the receiver is ready. Results leave through an output register, so a stalled
// receiver only holds the dump; the next command may be taken while the final
// result still waits. Reset empties every slot and sets the count to zero.
module top_k_largest_tracker_top
    import tkl_pkg::*;
#(
    parameter int MAX_SLOTS = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    tkl_in_if.sink           cmd_ch,
    tkl_out_if.source        res_ch
);

    localparam int MAX_COUNT = (1 << CNT_W) - 1;
    localparam int NUM_SLOTS = (MAX_SLOTS < MAX_COUNT) ? MAX_SLOTS : MAX_COUNT;
    localparam logic [CNT_W-1:0] SLOT_LIMIT = CNT_W'(NUM_SLOTS);

    logic [CNT_W-1:0] slots_in_use_reg;
    logic [CNT_W-1:0] n_act;
    dp_cmd_t          dp_cmd;
    dp_status_t       status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= '0;
        end
        else if (cfg_we)
        begin
            slots_in_use_reg <= cfg_wdata;
        end
    end

    assign n_act = (slots_in_use_reg > SLOT_LIMIT) ? SLOT_LIMIT : slots_in_use_reg;

    tkl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .n_act    (n_act),
        .in_valid (cmd_ch.valid),
        .in_cmd   (cmd_ch.cmd),
        .in_ready (cmd_ch.ready),
        .status   (status),
        .dp_cmd   (dp_cmd)
    );

    tkl_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .n_act      (n_act),
        .cand_label (cmd_ch.cand_label),
        .cand_value (cmd_ch.cand_value),
        .dp_cmd     (dp_cmd),
        .status     (status),
        .res_ch     (res_ch)
    );

endmodule

// ===== hw/rtl/tkl_ctrl.sv =====
module tkl_ctrl
    import tkl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] n_act,
    input  logic             in_valid,
    input  logic [1:0]       in_cmd,
    output logic             in_ready,
    input  dp_status_t       status,
    output dp_cmd_t          dp_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_WRITE = 5'b00100,
        ST_SORT  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] pass_reg, pass_next;
    logic             accept;
    logic             idx_is_last;
    logic             pass_is_last;

    assign in_ready     = (state_reg == ST_IDLE);
    assign accept       = in_valid && in_ready && (n_act != '0);
    assign idx_is_last  = ((idx_reg + CNT_W'(1)) == n_act);
    assign pass_is_last = ((pass_reg + CNT_W'(1)) == n_act);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pass_next  = pass_reg;
        dp_cmd     = '0;
        dp_cmd.idx = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_t'(in_cmd))
                        CMD_CLEAR:
                        begin
                            dp_cmd.clear = 1'b1;
                        end
                        CMD_OFFER:
                        begin
                            dp_cmd.load_cand = 1'b1;
                            idx_next         = '0;
                            state_next       = ST_SCAN;
                        end
                        CMD_DUMP:
                        begin
                            pass_next  = '0;
                            state_next = ST_SORT;
                        end
                        CMD_NONE:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                dp_cmd.scan = 1'b1;
                if (idx_is_last)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_WRITE:
            begin
                dp_cmd.write = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_SORT:
            begin
                dp_cmd.sort  = 1'b1;
                dp_cmd.phase = pass_reg[0];
                if (pass_is_last)
                begin
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    pass_next = pass_reg + CNT_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    dp_cmd.emit = 1'b1;
                    dp_cmd.last = idx_is_last;
                    if (idx_is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            pass_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pass_reg  <= pass_next;
        end
    end

endmodule

// ===== hw/rtl/tkl_datapath.sv =====
module tkl_datapath
    import tkl_pkg::*;
#(
    parameter int NUM_SLOTS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CNT_W-1:0]   n_act,
    input  logic [CAND_W-1:0]  cand_label,
    input  logic [VALUE_W-1:0] cand_value,
    input  dp_cmd_t            dp_cmd,
    output dp_status_t         status,
    tkl_out_if.source          res_ch
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [VALUE_W-1:0] slot_value_reg [NUM_SLOTS];
    logic [VALUE_W-1:0] slot_value_next[NUM_SLOTS];
    logic [LABEL_W-1:0] slot_label_reg [NUM_SLOTS];
    logic [LABEL_W-1:0] slot_label_next[NUM_SLOTS];

    logic [VALUE_W-1:0] cand_value_reg;
    logic [LABEL_W-1:0] cand_label_reg;
    logic [VALUE_W-1:0] min_value_reg;
    logic [IDX_W-1:0]   pick_reg;

    logic [IDX_W-1:0]   idx_sel;
    logic [VALUE_W-1:0] rd_value;
    logic [LABEL_W-1:0] rd_label;
    logic [NUM_SLOTS:0] pair_swap;
    logic               replace;

    logic                out_valid_reg;
    logic [RANK_W-1:0]   out_rank_reg;
    logic [LABEL_W-1:0]  out_label_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic                out_last_reg;

    assign idx_sel  = dp_cmd.idx[IDX_W-1:0];
    assign rd_value = slot_value_reg[idx_sel];
    assign rd_label = slot_label_reg[idx_sel];
    assign replace  = dp_cmd.write && (cand_value_reg > min_value_reg);

    // Odd-even transposition: bit k marks a swap of slots k-1 and k.
    always_comb
    begin
        pair_swap = '0;
        for (int k = 1; k < NUM_SLOTS; k++)
        begin
            pair_swap[k] = dp_cmd.sort
                           && (k[0] != dp_cmd.phase)
                           && (CNT_W'(k) < n_act)
                           && (slot_value_reg[k-1] < slot_value_reg[k]);
        end
    end

    always_comb
    begin
        for (int j = 0; j < NUM_SLOTS; j++)
        begin
            slot_value_next[j] = slot_value_reg[j];
            slot_label_next[j] = slot_label_reg[j];
            if (dp_cmd.clear)
            begin
                slot_value_next[j] = '0;
                slot_label_next[j] = LABEL_EMPTY;
            end
            else if (replace && (pick_reg == IDX_W'(j)))
            begin
                slot_value_next[j] = cand_value_reg;
                slot_label_next[j] = cand_label_reg;
            end
            else if ((j + 1 < NUM_SLOTS) && pair_swap[j+1])
            begin
                slot_value_next[j] = slot_value_reg[(j + 1 < NUM_SLOTS) ? j + 1 : j];
                slot_label_next[j] = slot_label_reg[(j + 1 < NUM_SLOTS) ? j + 1 : j];
            end
            else if (j > 0 && pair_swap[j])
            begin
                slot_value_next[j] = slot_value_reg[(j > 0) ? j - 1 : j];
                slot_label_next[j] = slot_label_reg[(j > 0) ? j - 1 : j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NUM_SLOTS; j++)
            begin
                slot_value_reg[j] <= '0;
                slot_label_reg[j] <= LABEL_EMPTY;
            end
        end
        else
        begin
            slot_value_reg <= slot_value_next;
            slot_label_reg <= slot_label_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_cand)
        begin
            cand_value_reg <= cand_value;
            cand_label_reg <= {1'b0, cand_label};
        end
        if (dp_cmd.scan && ((dp_cmd.idx == '0) || (rd_value < min_value_reg)))
        begin
            min_value_reg <= rd_value;
            pick_reg      <= idx_sel;
        end
        if (dp_cmd.emit)
        begin
            out_rank_reg  <= dp_cmd.idx[RANK_W-1:0];
            out_label_reg <= rd_label;
            out_value_reg <= rd_value;
            out_last_reg  <= dp_cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dp_cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_busy  = out_valid_reg && !res_ch.ready;
    assign res_ch.valid     = out_valid_reg;
    assign res_ch.rank      = out_rank_reg;
    assign res_ch.out_label = out_label_reg;
    assign res_ch.out_value = out_value_reg;
    assign res_ch.last      = out_last_reg;

endmodule

// ===== dv/tb_top_k_largest_tracker_top.sv =====
module tb_top_k_largest_tracker_top
    import tkl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_COUNT  = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 28;

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [LABEL_W-1:0] label;
        logic [VALUE_W-1:0] value;
        logic               last;
    } ranked_entry_t;

    class slot_tracker_model;
        logic [VALUE_W-1:0] slot_val [SLOT_COUNT];
        logic [LABEL_W-1:0] slot_lbl [SLOT_COUNT];
        int unsigned        slot_cfg;
        ranked_entry_t      pending[$];
        int                 errors;
        int                 checked;
        int                 offers;
        int                 dumps;
        int                 clears;
        int                 commands;

        function new();
            empty_slots();
            slot_cfg = 0;
            errors   = 0;
            checked  = 0;
            offers   = 0;
            dumps    = 0;
            clears   = 0;
            commands = 0;
        endfunction

        function void empty_slots();
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_val[i] = '0;
                slot_lbl[i] = LABEL_EMPTY;
            end
        endfunction

        function void set_count(int unsigned c);
            slot_cfg = c;
        endfunction

        function int unsigned in_use();
            return (slot_cfg > SLOT_COUNT) ? SLOT_COUNT : slot_cfg;
        endfunction

        function void note_command(cmd_t c, logic [CAND_W-1:0] lbl, logic [VALUE_W-1:0] val);
            int unsigned        n;
            int unsigned        pick;
            int unsigned        j;
            logic [VALUE_W-1:0] v;
            logic [LABEL_W-1:0] l;
            ranked_entry_t      e;
            n = in_use();
            commands++;
            case (c)
                CMD_CLEAR: clears++;
                CMD_OFFER: offers++;
                CMD_DUMP:  dumps++;
                default:   ;
            endcase
            if (n == 0)
                return;
            case (c)
                CMD_CLEAR:
                begin
                    empty_slots();
                end
                CMD_OFFER:
                begin
                    pick = 0;
                    for (int unsigned i = 1; i < n; i++)
                    begin
                        if (slot_val[i] < slot_val[pick])
                            pick = i;
                    end
                    if (val > slot_val[pick])
                    begin
                        slot_val[pick] = val;
                        slot_lbl[pick] = {1'b0, lbl};
                    end
                end
                CMD_DUMP:
                begin
                    for (int unsigned i = 1; i < n; i++)
                    begin
                        v = slot_val[i];
                        l = slot_lbl[i];
                        j = i;
                        while (j > 0 && slot_val[j-1] < v)
                        begin
                            slot_val[j] = slot_val[j-1];
                            slot_lbl[j] = slot_lbl[j-1];
                            j--;
                        end
                        slot_val[j] = v;
                        slot_lbl[j] = l;
                    end
                    for (int unsigned k = 0; k < n; k++)
                    begin
                        e.rank  = k[RANK_W-1:0];
                        e.label = slot_lbl[k];
                        e.value = slot_val[k];
                        e.last  = (k + 1 == n);
                        pending.push_back(e);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_entry(logic [RANK_W-1:0] rk, logic signed [LABEL_W-1:0] lb,
                                  logic [VALUE_W-1:0] vl, logic lst);
            ranked_entry_t e;
            if (pending.size() == 0)
            begin
                $error("result with nothing expected: rank %0d out_label %0d out_value %0h",
                       rk, lb, vl);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (rk !== e.rank)
            begin
                $error("rank: expected %0d, actual %0d", e.rank, rk);
                errors++;
            end
            if (lb !== $signed(e.label))
            begin
                $error("out_label: expected %0d, actual %0d", $signed(e.label), lb);
                errors++;
            end
            if (vl !== e.value)
            begin
                $error("out_value: expected %0h, actual %0h", e.value, vl);
                errors++;
            end
            if (lst !== e.last)
            begin
                $error("last: expected %0b, actual %0b", e.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    tkl_in_if  cmd_if ();
    tkl_out_if res_if ();

    top_k_largest_tracker_top #(
        .MAX_SLOTS (SLOT_COUNT)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_ch    (cmd_if),
        .res_ch    (res_if)
    );

    slot_tracker_model tracker = new();
    bit                hold_request;
    int                burst_left;
    int                settings_used;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            tracker.check_entry(res_if.rank, res_if.out_label, res_if.out_value, res_if.last);
    end

    // The receiver mixes long ready runs, short stalls and random toggling.
    initial
    begin
        int mode;
        int len;
        res_if.ready = 1'b0;
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    @(negedge clk);
                    res_if.ready <= 1'b0;
                end
            end
            else
            begin
                mode = $urandom_range(0, 3);
                case (mode)
                    0:       len = $urandom_range(20, 60);
                    1:       len = $urandom_range(1, 8);
                    2:       len = $urandom_range(10, 30);
                    default: len = $urandom_range(1, 3);
                endcase
                repeat (len)
                begin
                    @(negedge clk);
                    case (mode)
                        1:       res_if.ready <= 1'b0;
                        2:       res_if.ready <= $urandom_range(0, 1);
                        default: res_if.ready <= 1'b1;
                    endcase
                end
            end
        end
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 7);
            1:       return '0;
            2:       return '1;
            5:       return {4'($urandom_range(0, 15)), 28'h0};
            default: return $urandom;
        endcase
    endfunction

    task automatic pace();
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                cmd_if.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    task automatic send(input cmd_t c, input logic [CAND_W-1:0] lbl,
                        input logic [VALUE_W-1:0] val);
        pace();
        cmd_if.valid      <= 1'b1;
        cmd_if.cmd        <= c;
        cmd_if.cand_label <= lbl;
        cmd_if.cand_value <= val;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        tracker.note_command(c, lbl, val);
        @(negedge clk);
    endtask

    task automatic drain(input int settle);
        cmd_if.valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_slot_count(input logic [CNT_W-1:0] c);
        drain(2 * SLOT_COUNT + 8);
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(negedge clk);
        cfg_we    <= 1'b0;
        tracker.set_count(c);
        settings_used++;
    endtask

    task automatic random_frame();
        int k;
        if ($urandom_range(0, 9) == 0)
        begin
            send(cmd_t'($urandom_range(0, 3)), CAND_W'($urandom), $urandom);
        end
        else
        begin
            if ($urandom_range(0, 3) != 0)
                send(CMD_CLEAR, CAND_W'($urandom), $urandom);
            k = $urandom_range(0, 10);
            repeat (k) send(CMD_OFFER, CAND_W'($urandom), pick_value());
            send(CMD_DUMP, CAND_W'($urandom), $urandom);
        end
    endtask

    initial
    begin
        int unsigned phase_counts[12];
        int          start;
        phase_counts      = '{8, 2, 0, 5, 15, 1, 7, 3, 4, 6, 9, 8};
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        cmd_if.valid      = 1'b0;
        cmd_if.cmd        = CMD_CLEAR;
        cmd_if.cand_label = '0;
        cmd_if.cand_value = '0;
        hold_request      = 1'b0;
        burst_left        = 0;
        settings_used     = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Tracking is disabled straight out of reset.
        send(CMD_OFFER, 16'hFFFF, 32'hFFFF_FFFF);
        send(CMD_DUMP, '0, '0);
        send(CMD_CLEAR, '0, '0);
        send(CMD_NONE, CAND_W'($urandom), $urandom);

        write_slot_count(4'd8);
        send(CMD_DUMP, '0, '0);
        send(CMD_OFFER, 16'hFFFF, 32'hFFFF_FFFF);
        send(CMD_OFFER, 16'h0000, 32'h0);
        send(CMD_OFFER, 16'h1234, 32'h1);
        send(CMD_OFFER, 16'h8000, 32'h8000_0000);
        send(CMD_OFFER, 16'h0001, 32'h5);
        send(CMD_OFFER, 16'h0002, 32'h5);
        send(CMD_NONE, CAND_W'($urandom), $urandom);
        send(CMD_DUMP, CAND_W'($urandom), $urandom);
        send(CMD_OFFER, 16'h0003, 32'h5);
        send(CMD_DUMP, '0, '0);

        // Shrinking the count hides the upper slots without losing them.
        write_slot_count(4'd3);
        send(CMD_DUMP, '0, '0);
        send(CMD_OFFER, 16'h0007, 32'h9);
        write_slot_count(4'd8);
        send(CMD_DUMP, '0, '0);
        send(CMD_CLEAR, CAND_W'($urandom), $urandom);
        send(CMD_DUMP, '0, '0);

        write_slot_count(4'd15);
        send(CMD_OFFER, 16'h0004, 32'h6);
        send(CMD_DUMP, '0, '0);

        write_slot_count(4'd1);
        send(CMD_OFFER, 16'hAAAA, 32'h100);
        send(CMD_OFFER, 16'h5555, 32'h100);
        send(CMD_OFFER, 16'h5555, 32'hFF);
        send(CMD_DUMP, '0, '0);

        foreach (phase_counts[p])
        begin
            write_slot_count(CNT_W'(phase_counts[p]));
            if (p == 0)
                hold_request = 1'b1;
            start = tracker.commands;
            while (tracker.commands - start < PHASE_ITEMS)
                random_frame();
        end

        drain(2 * SLOT_COUNT + 24);
        $display("Ran %0d commands (%0d offers, %0d dumps, %0d clears) over %0d slot counts.",
                 tracker.commands, tracker.offers, tracker.dumps, tracker.clears,
                 settings_used);
        $display("Checked %0d ranked entries, including a %0d-cycle receiver stall.",
                 tracker.checked, HOLD_CYCLES);
        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
